@@ design/sac_pkg.sv @@
// Shared constants, types and sequencer states for the set-associative byte cache.
package sac_pkg;

   // Address and data geometry
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int CNT_W      = 32;
   localparam int NUM_WAYS   = 4;
   localparam int NUM_SETS   = 8;
   localparam int LINE_BYTES = 64;
   localparam int MEM_BYTES  = 65536;

   localparam int OFF_W      = $clog2(LINE_BYTES);
   localparam int SET_W      = $clog2(NUM_SETS);
   localparam int WAY_W      = $clog2(NUM_WAYS);
   localparam int TAG_W      = ADDR_W - OFF_W - SET_W;
   localparam int LINE_IDX_W = SET_W + WAY_W;
   localparam int NUM_LINES  = NUM_SETS * NUM_WAYS;
   localparam int LDATA_AW   = LINE_IDX_W + OFF_W;
   localparam int LDATA_DEPTH = NUM_LINES * LINE_BYTES;
   localparam int MEM_AW     = $clog2(MEM_BYTES);

   // Operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_HIT_READ,
      ST_FILL,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Main memory port request
   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [DATA_W-1:0] wdata;
      logic [MEM_AW-1:0] rd_addr;
   } mem_req_type;

   // Line data store request
   typedef struct packed {
      logic                wr_en;
      logic [LDATA_AW-1:0] wr_addr;
      logic [DATA_W-1:0]   wdata;
      logic [LDATA_AW-1:0] rd_addr;
   } line_req_type;

   // Tag directory control
   typedef struct packed {
      logic [LINE_IDX_W-1:0] rd_line;
      logic [LINE_IDX_W-1:0] cmp_line;
      logic [TAG_W-1:0]      cmp_tag;
      logic                  alloc_en;
      logic [SET_W-1:0]      alloc_set;
      logic [TAG_W-1:0]      alloc_tag;
   } tag_ctl_type;

   // Tag directory status
   typedef struct packed {
      logic             match;
      logic [WAY_W-1:0] victim;
   } tag_sts_type;

endpackage

@@ design/sac_main_mem.sv @@
// Byte-wide main memory with a zeroing sweep after reset.
module sac_main_mem
   import sac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data,
   output logic              clear_busy
);

   logic [DATA_W-1:0] mem [MEM_BYTES];
   logic [MEM_AW:0]   clr_cnt_ff;
   logic [MEM_AW:0]   clr_cnt_in;

   assign clear_busy = !clr_cnt_ff[MEM_AW];

   // Advance the clearing pointer until it passes the last entry
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (clear_busy) begin
         clr_cnt_in = clr_cnt_ff + (MEM_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Zero during the sweep, then take byte writes; read is registered
   always_ff @(posedge clock) begin
      if (clear_busy) begin
         mem[clr_cnt_ff[MEM_AW-1:0]] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wdata;
      end
      rd_data <= mem[mem_req.rd_addr];
   end

endmodule

@@ design/sac_line_store.sv @@
// Cached line bytes: one write port and one registered read port.
module sac_line_store
   import sac_pkg::*;
(
   input  logic              clock,
   input  line_req_type      line_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [LDATA_DEPTH];

   // Write one byte, read one byte
   always_ff @(posedge clock) begin
      if (line_req.wr_en) begin
         mem[line_req.wr_addr] <= line_req.wdata;
      end
      rd_data <= mem[line_req.rd_addr];
   end

endmodule

@@ design/sac_tag_dir.sv @@
// Tag directory: tag memory, valid bits, per-set victim pointers and the shared tag comparator.
module sac_tag_dir
   import sac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tag_ctl_type tag_ctl,
   output tag_sts_type tag_sts
);

   logic [TAG_W-1:0]     tag_mem [NUM_LINES];
   logic [TAG_W-1:0]     tag_q_ff;
   logic [NUM_LINES-1:0] valid_ff;
   logic [NUM_LINES-1:0] valid_in;
   logic [WAY_W-1:0]     victim_ff [NUM_SETS];
   logic [WAY_W-1:0]     victim_in [NUM_SETS];
   logic [WAY_W-1:0]     cur_victim;
   logic [LINE_IDX_W-1:0] alloc_line;

   assign cur_victim = victim_ff[tag_ctl.alloc_set];
   assign alloc_line = {tag_ctl.alloc_set, cur_victim};

   // Compare the tag read last cycle against the lookup tag
   assign tag_sts.match  = valid_ff[tag_ctl.cmp_line] && (tag_q_ff == tag_ctl.cmp_tag);
   assign tag_sts.victim = cur_victim;

   // Mark the allocated line valid and advance the set's pointer
   always_comb begin
      valid_in  = valid_ff;
      victim_in = victim_ff;
      if (tag_ctl.alloc_en) begin
         valid_in[alloc_line] = 1'b1;
         if (cur_victim == WAY_W'(NUM_WAYS - 1)) begin
            victim_in[tag_ctl.alloc_set] = '0;
         end else begin
            victim_in[tag_ctl.alloc_set] = cur_victim + WAY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int s = 0; s < NUM_SETS; s++) begin
            victim_ff[s] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         victim_ff <= victim_in;
      end
   end

   // Tag memory: write on allocation, registered read
   always_ff @(posedge clock) begin
      if (tag_ctl.alloc_en) begin
         tag_mem[alloc_line] <= tag_ctl.alloc_tag;
      end
      tag_q_ff <= tag_mem[tag_ctl.rd_line];
   end

endmodule

@@ design/set_assoc_cache_fifo_write_through_core.sv @@
// Top level: sequencer of the four-way write-through byte cache over its main memory.
//
//  channel  direction  ports                                           handshake
//  req      in         req_op, req_address, req_write_data             req_valid / req_ready
//  rsp      out        rsp_data, rsp_hit, rsp_miss_count,              rsp_valid / rsp_ready
//                      rsp_access_count
//
//  One transaction at a time. The tag compare visits one way per cycle, up to all four
//  ways, and stops at the first match.
//  A read miss copies the line one byte per cycle through the main memory read port.
//  After reset the main memory is zeroed one byte per cycle, with req_ready low. A stalled
//  response holds in the output register, and the next transaction is accepted meanwhile;
//  only its own response waits.
module set_assoc_cache_fifo_write_through_core
   import sac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_data,
   output logic              rsp_hit,
   output logic [CNT_W-1:0]  rsp_miss_count,
   output logic [CNT_W-1:0]  rsp_access_count
);

   state_type state_ff, state_in;

   logic              op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [WAY_W-1:0]  way_ff, way_in;
   logic              hit_ff, hit_in;
   logic [OFF_W:0]    cnt_ff, cnt_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]  access_ff, access_in;
   logic [CNT_W-1:0]  miss_ff, miss_in;

   logic              req_accept;
   logic              rsp_load;
   logic              last_way;
   logic              fill_last;
   logic              fill_wr;
   logic [OFF_W:0]    fill_prev;
   logic [DATA_W-1:0] data_sel;

   logic [OFF_W-1:0]  off_ff;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SET_W-1:0]  req_set;
   logic [ADDR_W-1:0] fill_addr;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rd_data;
   logic              clear_busy;
   line_req_type      line_req;
   logic [DATA_W-1:0] line_rd_data;
   tag_ctl_type       tag_ctl;
   tag_sts_type       tag_sts;

   // Address fields
   assign off_ff    = addr_ff[OFF_W-1:0];
   assign set_ff    = addr_ff[OFF_W+SET_W-1:OFF_W];
   assign tag_ff    = addr_ff[ADDR_W-1:OFF_W+SET_W];
   assign req_set   = req_address[OFF_W+SET_W-1:OFF_W];
   assign fill_addr = {tag_ff, set_ff, cnt_ff[OFF_W-1:0]};

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign last_way   = (way_ff == WAY_W'(NUM_WAYS - 1));
   assign fill_last  = (cnt_ff == (OFF_W + 1)'(LINE_BYTES));
   assign fill_prev  = cnt_ff - (OFF_W + 1)'(1);
   assign fill_wr    = (state_ff == ST_FILL) && (cnt_ff != '0);
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
   assign data_sel   = (op_ff == OP_READ && hit_ff) ? line_rd_data : data_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_miss_count   = miss_ff;
   assign rsp_access_count = access_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (tag_sts.match) begin
               state_in = (op_ff == OP_WRITE) ? ST_WRITE : ST_HIT_READ;
            end else if (last_way) begin
               state_in = (op_ff == OP_WRITE) ? ST_WRITE : ST_FILL;
            end
         end
         ST_HIT_READ: state_in = ST_RESP;
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory, line store and tag directory strobes
   always_comb begin
      mem_req.wr_en   = (state_ff == ST_WRITE);
      mem_req.wr_addr = addr_ff[MEM_AW-1:0];
      mem_req.wdata   = wdata_ff;
      mem_req.rd_addr = fill_addr[MEM_AW-1:0];

      line_req.rd_addr = {set_ff, way_ff, off_ff};
      line_req.wr_en   = 1'b0;
      line_req.wr_addr = {set_ff, way_ff, off_ff};
      line_req.wdata   = wdata_ff;
      case (state_ff)
         ST_FILL: begin
            line_req.wr_en   = fill_wr;
            line_req.wr_addr = {set_ff, tag_sts.victim, fill_prev[OFF_W-1:0]};
            line_req.wdata   = mem_rd_data;
         end
         ST_WRITE: begin
            line_req.wr_en = hit_ff;
         end
         default: begin
            line_req.wr_en = 1'b0;
         end
      endcase

      tag_ctl.rd_line   = {(state_ff == ST_IDLE) ? req_set : set_ff, way_in};
      tag_ctl.cmp_line  = {set_ff, way_ff};
      tag_ctl.cmp_tag   = tag_ff;
      tag_ctl.alloc_en  = (state_ff == ST_FILL) && fill_last;
      tag_ctl.alloc_set = set_ff;
      tag_ctl.alloc_tag = tag_ff;
   end

   // Datapath next values
   always_comb begin
      op_in        = op_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      way_in       = way_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      access_in    = access_ff;
      miss_in      = miss_ff;

      // Drop the response once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            way_in = '0;
            if (req_accept) begin
               op_in    = req_op;
               addr_in  = req_address;
               wdata_in = req_write_data;
               hit_in   = 1'b0;
               cnt_in   = '0;
            end
         end
         ST_LOOKUP: begin
            if (tag_sts.match) begin
               hit_in = 1'b1;
            end else if (!last_way) begin
               way_in = way_ff + WAY_W'(1);
            end
         end
         ST_FILL: begin
            cnt_in = cnt_ff + (OFF_W + 1)'(1);
            if (fill_wr && fill_prev[OFF_W-1:0] == off_ff) begin
               data_in = mem_rd_data;
            end
         end
         ST_WRITE: begin
            data_in = wdata_ff;
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_sel;
               rsp_hit_in   = hit_ff;
               access_in    = access_ff + CNT_W'(1);
               if (!hit_ff) begin
                  miss_in = miss_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            way_in = way_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         access_ff    <= '0;
         miss_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         access_ff    <= access_in;
         miss_ff      <= miss_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      wdata_ff    <= wdata_in;
      way_ff      <= way_in;
      hit_ff      <= hit_in;
      cnt_ff      <= cnt_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   sac_main_mem u_main_mem (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .rd_data    (mem_rd_data),
      .clear_busy (clear_busy)
   );

   sac_line_store u_line_store (
      .clock    (clock),
      .line_req (line_req),
      .rd_data  (line_rd_data)
   );

   sac_tag_dir u_tag_dir (
      .clock   (clock),
      .reset   (reset),
      .tag_ctl (tag_ctl),
      .tag_sts (tag_sts)
   );

endmodule
